>>> hw/rtl/srpq_pkg.sv
// ----------------------------------------------------------------------------
// srpq_pkg: shared definitions of the sorted ring priority queue
// Store geometry, field widths, entry layout, command and status codes, and
// the ring address helpers used by the queue and its channel interfaces.
// ----------------------------------------------------------------------------
package srpq_pkg;

  // Number of cells in the entry store.
  localparam int Depth  = 16;
  localparam int AddrW  = $clog2(Depth);
  localparam int CntW   = $clog2(Depth + 1);

  localparam int PrioW  = 8;
  localparam int PayW   = 32;
  localparam int CapW   = 5;
  localparam int StatW  = 2;

  localparam logic [CapW-1:0] CapReset = CapW'(16);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_POPPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [PayW-1:0]  payload;
  } entry_t;

  typedef struct packed {
    status_e          status;
    logic [PrioW-1:0] prio;
    logic [PayW-1:0]  payload;
    logic [CntW-1:0]  occupancy;
  } result_t;

  // Next cell up the ring.
  function automatic logic [AddrW-1:0] ring_inc(input logic [AddrW-1:0] a);
    return (a == AddrW'(Depth - 1)) ? '0 : a + 1'b1;
  endfunction

  // Next cell down the ring.
  function automatic logic [AddrW-1:0] ring_dec(input logic [AddrW-1:0] a);
    return (a == '0) ? AddrW'(Depth - 1) : a - 1'b1;
  endfunction

  // Cell at a given offset from a base; the offset stays below the depth.
  function automatic logic [AddrW-1:0] ring_add(input logic [AddrW-1:0] a,
                                                input logic [CntW-1:0]  off);
    logic [AddrW:0] s;
    s = {1'b0, a} + (AddrW + 1)'(off);
    if (s >= (AddrW + 1)'(Depth)) begin
      s = s - (AddrW + 1)'(Depth);
    end
    return s[AddrW-1:0];
  endfunction

endpackage

>>> hw/rtl/srpq_if.sv
// ----------------------------------------------------------------------------
// srpq_if: channel interfaces of the sorted ring priority queue
// Request, response and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface srpq_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [srpq_pkg::PrioW-1:0]  priority_req;
  logic [srpq_pkg::PayW-1:0]   payload;

  modport source (output valid, cmd, priority_req, payload, input ready);
  modport sink   (input valid, cmd, priority_req, payload, output ready);
endinterface

interface srpq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [srpq_pkg::StatW-1:0]  status;
  logic [srpq_pkg::PrioW-1:0]  out_priority;
  logic [srpq_pkg::PayW-1:0]   out_payload;
  logic [srpq_pkg::CntW-1:0]   occupancy;

  modport source (output valid, status, out_priority, out_payload, occupancy,
                  input ready);
  modport sink   (input valid, status, out_priority, out_payload, occupancy,
                  output ready);
endinterface

interface srpq_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [srpq_pkg::CapW-1:0]   capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

>>> hw/rtl/sorted_ring_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_ring_priority_queue: bounded max-priority queue in a sorted ring
// Entries sit in ascending priority order in a store with one write port and
// one registered read port; inserts scan and shift cells one at a time.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Fields                                        Transfer when
//   req_i     in    cmd, priority_req, payload                    valid & ready
//   rsp_o     out   status, out_priority, out_payload, occupancy  valid & ready
//   cfg_i     in    capacity                                      valid & ready
//
// One request is worked on at a time; req_i.ready is high only while idle.
// A rejected insert, an empty pop or an insert into an empty queue goes
// straight to the response state; a pop first reads the top cell. Any other
// insert that lands at offset k among n entries compares s = min(k + 1, n)
// entries and moves m = min(k, n - k) cells; the store gives one read per
// cycle, and each moved cell is read and then written back. Reset clears the
// count, both ring pointers and the response valid flag and sets the
// capacity to 16; the store itself is not cleared. A stalled response only
// holds the block in its final state until the transfer.
module sorted_ring_priority_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  srpq_cfg_if.sink      cfg_i,
  srpq_req_if.sink      req_i,
  srpq_rsp_if.source    rsp_o
);

  // Controller states.
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request transfer
  localparam logic [2:0] S_SCAN = 3'd1;  // compare one stored entry per cycle
  localparam logic [2:0] S_MOVE = 3'd2;  // read next cell to shift, or place
  localparam logic [2:0] S_MVWR = 3'd3;  // write the shifted cell outward
  localparam logic [2:0] S_POP  = 3'd4;  // top entry arrives from the store
  localparam logic [2:0] S_RESP = 3'd5;  // hand the result to the response

  // Entry store: one write and one registered read per cycle.
  srpq_pkg::entry_t mem [srpq_pkg::Depth];
  srpq_pkg::entry_t rd_q;
  logic                          mem_we;
  logic [srpq_pkg::AddrW-1:0]    mem_wa;
  srpq_pkg::entry_t              mem_wd;
  logic                          mem_re;
  logic [srpq_pkg::AddrW-1:0]    mem_ra;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // Control state.
  logic [2:0]                  state_q, state_d;
  logic [srpq_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [srpq_pkg::AddrW-1:0]  low_q, low_d;
  logic [srpq_pkg::AddrW-1:0]  top_q, top_d;
  logic [srpq_pkg::CapW-1:0]   cap_q;
  logic                        rsp_valid_q, rsp_valid_d;

  // Working registers of the item in flight.
  srpq_pkg::entry_t            item_q, item_d;
  logic [srpq_pkg::CntW-1:0]   k_q, k_d;        // scan offset from low end
  logic [srpq_pkg::CntW-1:0]   n_q, n_d;        // cells still to shift
  logic [srpq_pkg::AddrW-1:0]  pos_q, pos_d;    // cell to shift next
  logic                        up_q, up_d;      // shift toward the top end
  srpq_pkg::result_t           res_q, res_d;
  srpq_pkg::result_t           out_q, out_d;

  // Scan helpers.
  logic                        le;
  logic [srpq_pkg::CntW-1:0]   k_inc;
  logic [srpq_pkg::CntW-1:0]   k_fin;
  logic                        full;
  logic [srpq_pkg::AddrW-1:0]  dst;

  // The queue is full once the count reaches the capacity or the store depth.
  assign full  = (32'(cnt_q) >= 32'(cap_q)) || (cnt_q == srpq_pkg::CntW'(srpq_pkg::Depth));
  assign le    = (rd_q.prio <= item_q.prio);
  assign k_inc = k_q + 1'b1;
  assign k_fin = le ? k_inc : k_q;
  // Shifted cells move one step outward, away from the insertion point.
  assign dst   = up_q ? srpq_pkg::ring_inc(pos_q) : srpq_pkg::ring_dec(pos_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    low_d       = low_q;
    top_d       = top_q;
    item_d      = item_q;
    k_d         = k_q;
    n_d         = n_q;
    pos_d       = pos_q;
    up_d        = up_q;
    res_d       = res_q;
    out_d       = out_q;
    rsp_valid_d = rsp_valid_q & ~rsp_o.ready;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = item_q;
    mem_re      = 1'b0;
    mem_ra      = '0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          item_d.prio    = req_i.priority_req;
          item_d.payload = req_i.payload;
          res_d.prio     = '0;
          res_d.payload  = '0;
          res_d.occupancy = cnt_q;
          state_d        = S_RESP;
          if (req_i.cmd == srpq_pkg::CMD_INSERT) begin
            if (full) begin
              res_d.status = srpq_pkg::ST_FULL;
            end else if (cnt_q == '0) begin
              // First entry always lands in cell zero.
              mem_we          = 1'b1;
              mem_wa          = '0;
              mem_wd.prio     = req_i.priority_req;
              mem_wd.payload  = req_i.payload;
              low_d           = '0;
              top_d           = '0;
              cnt_d           = srpq_pkg::CntW'(1);
              res_d.status    = srpq_pkg::ST_INSERTED;
              res_d.occupancy = srpq_pkg::CntW'(1);
            end else begin
              // Start the scan at the lowest entry.
              mem_re  = 1'b1;
              mem_ra  = low_q;
              k_d     = '0;
              state_d = S_SCAN;
            end
          end else begin
            if (cnt_q == '0) begin
              res_d.status = srpq_pkg::ST_EMPTY;
            end else begin
              mem_re  = 1'b1;
              mem_ra  = top_q;
              state_d = S_POP;
            end
          end
        end
      end

      S_SCAN: begin
        if (le && (k_inc != cnt_q)) begin
          // Entry at or below the new priority: keep walking upward.
          k_d    = k_inc;
          mem_re = 1'b1;
          mem_ra = srpq_pkg::ring_add(low_q, k_inc);
        end else begin
          // The new entry goes at offset k_fin; shift the shorter side.
          k_d     = k_fin;
          state_d = S_MOVE;
          if (k_fin < (cnt_q - k_fin)) begin
            up_d  = 1'b0;
            pos_d = low_q;
            n_d   = k_fin;
          end else begin
            up_d  = 1'b1;
            pos_d = top_q;
            n_d   = cnt_q - k_fin;
          end
        end
      end

      S_MOVE: begin
        if (n_q == '0) begin
          // All cells on that side moved; the freed cell takes the new entry.
          mem_we = 1'b1;
          mem_wa = dst;
          mem_wd = item_q;
          if (up_q) begin
            top_d = srpq_pkg::ring_inc(top_q);
          end else begin
            low_d = srpq_pkg::ring_dec(low_q);
          end
          cnt_d           = cnt_q + 1'b1;
          res_d.status    = srpq_pkg::ST_INSERTED;
          res_d.occupancy = cnt_q + 1'b1;
          state_d         = S_RESP;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = pos_q;
          state_d = S_MVWR;
        end
      end

      S_MVWR: begin
        mem_we  = 1'b1;
        mem_wa  = dst;
        mem_wd  = rd_q;
        pos_d   = up_q ? srpq_pkg::ring_dec(pos_q) : srpq_pkg::ring_inc(pos_q);
        n_d     = n_q - 1'b1;
        state_d = S_MOVE;
      end

      S_POP: begin
        res_d.status    = srpq_pkg::ST_POPPED;
        res_d.prio      = rd_q.prio;
        res_d.payload   = rd_q.payload;
        res_d.occupancy = cnt_q - 1'b1;
        cnt_d           = cnt_q - 1'b1;
        if (cnt_q == srpq_pkg::CntW'(1)) begin
          // Queue drained: both pointers go back to cell zero.
          low_d = '0;
          top_d = '0;
        end else begin
          top_d = srpq_pkg::ring_dec(top_q);
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          out_d       = res_q;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      low_q       <= '0;
      top_q       <= '0;
      cap_q       <= srpq_pkg::CapReset;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      low_q       <= low_d;
      top_q       <= top_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid) begin
        cap_q <= cfg_i.capacity;
      end
    end
  end

  // Working and payload registers need no reset.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    k_q    <= k_d;
    n_q    <= n_d;
    pos_q  <= pos_d;
    up_q   <= up_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // The capacity register takes a write in any cycle.
  assign cfg_i.ready        = 1'b1;
  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.out_priority = out_q.prio;
  assign rsp_o.out_payload  = out_q.payload;
  assign rsp_o.occupancy    = out_q.occupancy;

`ifndef SYNTH
  // The count never exceeds the store depth.
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= srpq_pkg::CntW'(srpq_pkg::Depth))
    else $error("entry count above store depth");

  // A non-empty queue spans exactly count cells from the low pointer.
  a_ring_span : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (top_q == srpq_pkg::ring_add(low_q, cnt_q - 1'b1)))
    else $error("ring pointers disagree with entry count");

  // An empty queue keeps both pointers at cell zero.
  a_empty_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (low_q == '0 && top_q == '0))
    else $error("stale ring pointers on empty queue");

  // A finished pop lowers the count by exactly one.
  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("pop did not remove exactly one entry");
`endif

endmodule
